[rtl/ictf_pkg.sv]
// ----------------------------------------------------------------------------
// ictf_pkg: shared types and helpers for the IPv6 canonical text formatter
// Holds the stage payload structures, the "no run" code and the character
// helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package ictf_pkg;

  localparam int unsigned NumGroups = 8;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned CharW     = 8;

  // Group index meaning that no zero run is collapsed.
  localparam logic [3:0] NoRun = 4'd8;

  localparam logic [CharW-1:0] CharColon = 8'h3A;

  // Result of the first stage: raw groups plus per-group summaries.
  typedef struct packed {
    logic [NumGroups-1:0][GroupW-1:0] grp;
    logic [NumGroups-1:0][1:0]        ndig;  // significant hex digits minus one
    logic [NumGroups-1:0]             zero;
  } scan_t;

  // Result of the second stage: what the character sequencer needs.
  typedef struct packed {
    logic [NumGroups-1:0][GroupW-1:0] grp;
    logic [NumGroups-1:0][1:0]        ndig;
    logic [3:0]                       run_start;  // NoRun when nothing collapses
    logic [3:0]                       run_end;    // first group after the run
  } item_t;

  // Lowercase ASCII hex digit.
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

[rtl/ictf_scan.sv]
// ----------------------------------------------------------------------------
// ictf_scan: input stage
// Registers the eight groups together with a zero flag and the number of
// significant hex digits of each group.
// ----------------------------------------------------------------------------
module ictf_scan (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  input  logic [ictf_pkg::NumGroups-1:0][ictf_pkg::GroupW-1:0] grp_i,
  output logic                                               in_ready_o,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output ictf_pkg::scan_t                                    out_o
);

  ictf_pkg::scan_t scan_d, scan_q;
  logic            valid_q;

  always_comb begin
    scan_d.grp = grp_i;
    for (int i = 0; i < ictf_pkg::NumGroups; i++) begin
      scan_d.zero[i] = (grp_i[i] == '0);
      if (grp_i[i][15:12] != 4'h0) begin
        scan_d.ndig[i] = 2'd3;
      end else if (grp_i[i][11:8] != 4'h0) begin
        scan_d.ndig[i] = 2'd2;
      end else if (grp_i[i][7:4] != 4'h0) begin
        scan_d.ndig[i] = 2'd1;
      end else begin
        scan_d.ndig[i] = 2'd0;
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      scan_q <= scan_d;
    end
  end

endmodule

[rtl/ictf_run.sv]
// ----------------------------------------------------------------------------
// ictf_run: zero-run stage
// Finds the first longest run of zero groups and keeps it only when it spans
// at least two groups.
// ----------------------------------------------------------------------------
module ictf_run (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ictf_pkg::scan_t  in_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ictf_pkg::item_t  out_o
);

  ictf_pkg::item_t item_d, item_q;
  logic            valid_q;

  always_comb begin
    logic [3:0] zrun_head;
    logic [3:0] cur_len;
    logic [3:0] long_head;
    logic [3:0] long_len;
    zrun_head = 4'd0;
    cur_len   = 4'd0;
    long_head = ictf_pkg::NoRun;
    long_len  = 4'd0;
    for (int i = 0; i < ictf_pkg::NumGroups; i++) begin
      if (in_i.zero[i]) begin
        if (cur_len == 4'd0) begin
          zrun_head = 4'(i);
        end
        cur_len = cur_len + 4'd1;
        if (cur_len > long_len) begin
          long_len  = cur_len;
          long_head = zrun_head;
        end
      end else begin
        cur_len = 4'd0;
      end
    end
    item_d.grp  = in_i.grp;
    item_d.ndig = in_i.ndig;
    if (long_len < 4'd2) begin
      item_d.run_start = ictf_pkg::NoRun;
      item_d.run_end   = ictf_pkg::NoRun;
    end else begin
      item_d.run_start = long_head;
      item_d.run_end   = long_head + long_len;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

`ifndef SYNTH
  // A collapsed run always covers two groups or more.
  a_run_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && item_q.run_start != ictf_pkg::NoRun) |->
      (item_q.run_end >= item_q.run_start + 4'd2))
    else $error("collapsed run shorter than two groups");
`endif

endmodule

[rtl/ictf_emit.sv]
// ----------------------------------------------------------------------------
// ictf_emit: character sequencer
// Walks one address group by group and emits one ASCII character per cycle
// through a registered output.
// ----------------------------------------------------------------------------
module ictf_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  ictf_pkg::item_t             in_item_i,
  output logic                        in_ready_o,
  output logic                        char_valid_o,
  output logic [ictf_pkg::CharW-1:0]  text_char_o,
  output logic                        last_char_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StSep    = 5'b00010,
    StDigit  = 5'b00100,
    StColon1 = 5'b01000,
    StColon2 = 5'b10000
  } state_e;

  typedef struct packed {
    state_e     state;
    logic [2:0] gi;
    logic [1:0] di;
    logic       done;
  } step_t;

  // Moves on to group g: collapsed run, separator first, or digits directly; past the last group it ends the address.
  function automatic step_t enter_group(input logic [3:0] g, input logic sep,
                                        input logic [3:0] run_start,
                                        input logic [1:0] ndig_g);
    step_t s;
    s.state = StIdle;
    s.gi    = g[2:0];
    s.di    = ndig_g;
    s.done  = 1'b0;
    if (g[3]) begin
      s.done = 1'b1;
    end else if (g == run_start) begin
      s.state = StColon1;
    end else if (sep) begin
      s.state = StSep;
    end else begin
      s.state = StDigit;
    end
    return s;
  endfunction

  state_e                     state_d, state_q;
  logic [2:0]                 gi_d, gi_q;
  logic [1:0]                 di_d, di_q;
  ictf_pkg::item_t            item_q;
  step_t                      step;
  step_t                      load;
  logic [3:0]                 gi_next;
  logic                       take;
  logic [ictf_pkg::GroupW-1:0] grp_sel;
  logic [3:0]                 nib;
  logic [ictf_pkg::CharW-1:0] char_d, char_q;
  logic                       char_valid_q;
  logic                       last_d, last_q;

  always_comb begin
    gi_next = {1'b0, gi_q} + 4'd1;
    step    = '{state: StIdle, gi: gi_q, di: di_q, done: 1'b1};
    case (state_q)
      StSep: begin
        step = '{state: StDigit, gi: gi_q, di: item_q.ndig[gi_q], done: 1'b0};
      end
      StDigit: begin
        if (di_q != 2'd0) begin
          step = '{state: StDigit, gi: gi_q, di: di_q - 2'd1, done: 1'b0};
        end else begin
          step = enter_group(gi_next, 1'b1, item_q.run_start,
                             item_q.ndig[gi_next[2:0]]);
        end
      end
      StColon1: begin
        step = '{state: StColon2, gi: gi_q, di: di_q, done: 1'b0};
      end
      StColon2: begin
        step = enter_group(item_q.run_end, 1'b0, item_q.run_start,
                           item_q.ndig[item_q.run_end[2:0]]);
      end
      default: begin
        step = '{state: StIdle, gi: gi_q, di: di_q, done: 1'b1};
      end
    endcase

    load = enter_group(4'd0, 1'b0, in_item_i.run_start, in_item_i.ndig[0]);
    take = in_valid_i && step.done;

    if (take) begin
      state_d = load.state;
      gi_d    = load.gi;
      di_d    = load.di;
    end else if (step.done) begin
      state_d = StIdle;
      gi_d    = gi_q;
      di_d    = di_q;
    end else begin
      state_d = step.state;
      gi_d    = step.gi;
      di_d    = step.di;
    end
  end

  always_comb begin
    grp_sel = item_q.grp[gi_q];
    nib     = grp_sel[{di_q, 2'b00} +: 4];
    case (state_q)
      StDigit:  char_d = ictf_pkg::hex_char(nib);
      StSep:    char_d = ictf_pkg::CharColon;
      StColon1: char_d = ictf_pkg::CharColon;
      StColon2: char_d = ictf_pkg::CharColon;
      default:  char_d = '0;
    endcase
    last_d = step.done && (state_q != StIdle);
  end

  assign in_ready_o   = step.done;
  assign char_valid_o = char_valid_q;
  assign text_char_o  = char_q;
  assign last_char_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      char_valid_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      char_valid_q <= (state_q != StIdle);
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gi_q   <= gi_d;
    di_q   <= di_d;
    char_q <= char_d;
    if (take) begin
      item_q <= in_item_i;
    end
  end

`ifndef SYNTH
  // The digit position never exceeds the significant digits of the group.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit) |-> (di_q <= item_q.ndig[gi_q]))
    else $error("digit position beyond significant digits");

  // The double colon is always emitted as a pair.
  a_colon_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StColon1) |=> (state_q == StColon2))
    else $error("double colon broken");

  // A character transfer follows a cycle spent on an address.
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_q |-> $past(state_q != StIdle))
    else $error("character strobe without active address");
`endif

endmodule

[rtl/ipv6_canonical_text_formatter.sv]
// ----------------------------------------------------------------------------
// ipv6_canonical_text_formatter: IPv6 address to canonical text
// Three-stage pipeline that turns one 128-bit address into its compressed
// lowercase hex text, one ASCII character per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   An address transfer takes place at a rising edge where start is high and
//   busy is low; group_0_i .. group_7_i carry the eight groups, group_0_i
//   first. The text leaves as a stream of characters: char_valid_o marks a
//   cycle that holds one character on text_char_o, and last_char_o marks the
//   final character of an address. Every marked cycle is a transfer; the
//   receiver has no way to hold characters off.
//   Stages: the scan stage registers the groups with zero flags and digit
//   counts, the run stage picks the first longest zero run (two groups or
//   more), and the sequencer walks the address one character per cycle into
//   an output register.
//   Path: an address passes the scan register and the run register, waits
//   for the sequencer to take it, and leaves through the output register.
//   Overlap: an address yields 2 to 39 characters and holds the character
//   sequencer until its last character is out. The next address enters
//   the scan and run stages while the current text is still being emitted,
//   and the sequencer starts it right after the last character, so the
//   texts follow each other without a gap. busy rises only when both
//   stages already hold waiting work.
//   Reset empties all stages and clears the character strobe.
module ipv6_canonical_text_formatter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ictf_pkg::GroupW-1:0] group_0_i,
  input  logic [ictf_pkg::GroupW-1:0] group_1_i,
  input  logic [ictf_pkg::GroupW-1:0] group_2_i,
  input  logic [ictf_pkg::GroupW-1:0] group_3_i,
  input  logic [ictf_pkg::GroupW-1:0] group_4_i,
  input  logic [ictf_pkg::GroupW-1:0] group_5_i,
  input  logic [ictf_pkg::GroupW-1:0] group_6_i,
  input  logic [ictf_pkg::GroupW-1:0] group_7_i,
  output logic                        char_valid_o,
  output logic [ictf_pkg::CharW-1:0]  text_char_o,
  output logic                        last_char_o
);

  logic [ictf_pkg::NumGroups-1:0][ictf_pkg::GroupW-1:0] grp_in;

  logic            scan_ready;
  logic            scan_valid;
  ictf_pkg::scan_t scan_data;
  logic            run_ready;
  logic            run_valid;
  ictf_pkg::item_t run_item;
  logic            emit_ready;

  // Index 0 holds the first group.
  assign grp_in = {group_7_i, group_6_i, group_5_i, group_4_i,
                   group_3_i, group_2_i, group_1_i, group_0_i};

  assign busy = !scan_ready;

  ictf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .grp_i       (grp_in),
    .in_ready_o  (scan_ready),
    .out_valid_o (scan_valid),
    .out_ready_i (run_ready),
    .out_o       (scan_data)
  );

  ictf_run u_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scan_valid),
    .in_i        (scan_data),
    .in_ready_o  (run_ready),
    .out_valid_o (run_valid),
    .out_ready_i (emit_ready),
    .out_o       (run_item)
  );

  ictf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (run_valid),
    .in_item_i    (run_item),
    .in_ready_o   (emit_ready),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

`ifndef SYNTH
  // An address waiting in the run stage is not dropped before the sequencer
  // takes it.
  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_valid && !emit_ready) |=> run_valid)
    else $error("pending address lost before the sequencer took it");
`endif

endmodule

[sim/ipv6_canonical_text_formatter_test.sv]
// ----------------------------------------------------------------------------
// ipv6_canonical_text_formatter_test: self-checking bench for the formatter
// Sends directed and random IPv6 addresses and predicts their compressed
// lowercase text. A scoreboard compares every character and end marker that
// the block emits, while the sender runs both back to back and with gaps.
// ----------------------------------------------------------------------------
module ipv6_canonical_text_formatter_test;

  typedef logic [ictf_pkg::NumGroups-1:0][ictf_pkg::GroupW-1:0] addr_t;

  // One character of expected text together with its end-of-address marker.
  typedef struct {
    logic [ictf_pkg::CharW-1:0] ch;
    logic                       last;
  } text_char_t;

  // The scoreboard turns each accepted address into the characters it must
  // produce and then checks the character stream against them in order.
  class text_scoreboard;
    text_char_t  expected_text[$];
    int unsigned mismatches;
    int unsigned addresses;
    int unsigned chars_checked;

    function logic [ictf_pkg::CharW-1:0] hex_digit(logic [3:0] nib);
      string digits = "0123456789abcdef";
      return digits[nib];
    endfunction

    function void note_address(addr_t grp);
      int                         run_start;
      int                         run_len;
      int                         zrun_head;
      int                         cur_len;
      int                         idx;
      int                         shift;
      logic [3:0]                 nib;
      bit                         started;
      logic [ictf_pkg::CharW-1:0] text[$];
      text_char_t                 entry;

      // Find the first longest run of zero groups.
      run_start = ictf_pkg::NumGroups;
      run_len   = 0;
      zrun_head = 0;
      cur_len   = 0;
      for (idx = 0; idx < ictf_pkg::NumGroups; idx++) begin
        if (grp[idx] == '0) begin
          if (cur_len == 0) zrun_head = idx;
          cur_len++;
          if (cur_len > run_len) begin
            run_len   = cur_len;
            run_start = zrun_head;
          end
        end else begin
          cur_len = 0;
        end
      end
      // A lone zero group is printed, not collapsed.
      if (run_len < 2) begin
        run_start = ictf_pkg::NumGroups;
        run_len   = 0;
      end

      idx = 0;
      while (idx < ictf_pkg::NumGroups) begin
        if (idx == run_start) begin
          text.push_back(ictf_pkg::CharColon);
          text.push_back(ictf_pkg::CharColon);
          idx += run_len;
        end else begin
          // No separator right after the double colon or at the very start.
          if (text.size() > 0 && text[text.size()-1] != ictf_pkg::CharColon) begin
            text.push_back(ictf_pkg::CharColon);
          end
          started = 1'b0;
          for (shift = 12; shift >= 0; shift -= 4) begin
            nib = grp[idx][shift +: 4];
            if (nib != 4'h0 || started || shift == 0) begin
              started = 1'b1;
              text.push_back(hex_digit(nib));
            end
          end
          idx++;
        end
      end

      foreach (text[k]) begin
        entry.ch   = text[k];
        entry.last = (k == text.size() - 1);
        expected_text.push_back(entry);
      end
      addresses++;
    endfunction

    function void check_char(logic [ictf_pkg::CharW-1:0] ch, logic last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, ch, last);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      chars_checked++;
      if (ch !== want.ch) begin
        $display("%0t: text_char mismatch: expected %h, actual %h", $time, want.ch, ch);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last_char mismatch: expected %b, actual %b", $time, want.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_text.size();
    endfunction
  endclass

  localparam int unsigned RandomPerPhase = 83;
  localparam int unsigned DrainGuard     = 5000;
  localparam int unsigned SettleCycles   = 8;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  addr_t                       addr_q;
  logic                        char_valid_o;
  logic [ictf_pkg::CharW-1:0]  text_char_o;
  logic                        last_char_o;

  text_scoreboard sb = new();

  ipv6_canonical_text_formatter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .group_0_i    (addr_q[0]),
    .group_1_i    (addr_q[1]),
    .group_2_i    (addr_q[2]),
    .group_3_i    (addr_q[3]),
    .group_4_i    (addr_q[4]),
    .group_5_i    (addr_q[5]),
    .group_6_i    (addr_q[6]),
    .group_7_i    (addr_q[7]),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every strobed cycle is a transfer that the receiver cannot refuse, so each
  // one is checked at the rising edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && char_valid_o === 1'b1) begin
      sb.check_char(text_char_o, last_char_o);
    end
  end

  // Safety net in case the block stops answering.
  initial begin
    #2000000;
    $display("ipv6_canonical_text_formatter_test NOT OK");
    $finish;
  end

  // A group that is zero with the given odds, otherwise holds one to four
  // significant hex digits so that leading-zero suppression gets exercised.
  function automatic logic [ictf_pkg::GroupW-1:0] random_group(int unsigned zero_pct);
    int unsigned digits;
    if ($urandom_range(99) < zero_pct) return '0;
    digits = $urandom_range(1, 4);
    return 16'($urandom_range(1, (1 << (4 * digits)) - 1));
  endfunction

  // Random addresses lean toward zero-rich shapes, since the run search and
  // the colon placement are where the interesting behavior lives.
  function automatic addr_t random_address();
    addr_t       a;
    int unsigned shape;
    int unsigned zero_pct;
    int unsigned run_at;
    int unsigned run_len;
    shape    = $urandom_range(9);
    zero_pct = $urandom_range(20, 70);
    run_at   = $urandom_range(0, ictf_pkg::NumGroups - 1);
    run_len  = $urandom_range(1, ictf_pkg::NumGroups - run_at);
    for (int g = 0; g < ictf_pkg::NumGroups; g++) begin
      if (shape < 2) begin
        a[g] = 16'($urandom_range(0, 16'hffff));
      end else if (shape < 6) begin
        a[g] = random_group(zero_pct);
      end else begin
        a[g] = (g >= run_at && g < run_at + run_len) ? '0 : random_group(30);
      end
    end
    return a;
  endfunction

  // Offers one address and holds it until the block takes it. With the given
  // odds the sender first idles and puts noise on the groups.
  task automatic send_address(addr_t a, int unsigned idle_pct);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      start  = 1'b0;
      addr_q = random_address();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  = 1'b1;
    addr_q = a;
    do @(posedge clk_i); while (busy);
    sb.note_address(a);
  endtask

  // Lowers start and waits until every predicted character has come out.
  task automatic drain_text();
    int unsigned guard;
    guard = 0;
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Directed addresses, written in reading order: group 0 is the leftmost.
  logic [127:0] directed_addr[] = '{
    128'h0000_0000_0000_0000_0000_0000_0000_0000,  // all zero
    128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
    128'h0001_0000_0000_0000_0000_0000_0000_0000,  // run to the end
    128'h0000_0000_0000_0000_0000_0000_0000_0001,  // run from the start
    128'h0000_0000_0000_0000_0000_0000_0001_0000,
    128'hfe80_0000_0000_0000_0000_0000_0000_0000,
    128'h2001_0db8_0000_0000_0000_ff00_0042_8329,
    128'h2001_0db8_0000_0001_0001_0001_0001_0001,  // single zero group
    128'h2001_0000_0000_0001_0000_0000_0000_0001,  // later run is longer
    128'h2001_0db8_0000_0000_0001_0000_0000_0001,  // equal runs, first wins
    128'h0000_0000_ffff_ffff_ffff_ffff_0000_0000,  // equal runs at both ends
    128'hffff_0000_0000_0000_0000_0000_0000_ffff,
    128'h0000_0001_0000_0001_0000_0001_0000_0001,  // only lone zeros
    128'h0001_0000_0001_0000_0001_0000_0001_0000,
    128'h0000_ffff_ffff_ffff_ffff_ffff_ffff_0000,
    128'h000f_00f0_0f00_f000_abcd_ef01_2345_6789,
    128'haaaa_5555_aaaa_5555_aaaa_5555_aaaa_5555,
    128'h5555_aaaa_5555_aaaa_5555_aaaa_5555_aaaa,
    128'h8000_4000_2000_1000_0800_0400_0200_0100,
    128'h0080_0040_0020_0010_0008_0004_0002_0001,
    128'h0000_0000_0000_0001_0000_0000_0000_0000   // longer run at the end
  };

  // Sender idle odds per random phase: none, heavy, light.
  int unsigned idle_phases[3] = '{0, 54, 11};

  initial begin
    addr_t a;
    rst_ni = 1'b0;
    start  = 1'b0;
    addr_q = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed addresses back to back, then a full pause before random work.
    foreach (directed_addr[d]) begin
      for (int g = 0; g < ictf_pkg::NumGroups; g++) begin
        a[g] = directed_addr[d][127 - 16 * g -: 16];
      end
      send_address(a, 0);
    end
    drain_text();

    foreach (idle_phases[p]) begin
      for (int n = 0; n < RandomPerPhase; n++) begin
        send_address(random_address(), idle_phases[p]);
      end
      drain_text();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, sb.pending());
      sb.mismatches++;
    end

    $display("Formatted %0d addresses into %0d checked characters,", sb.addresses,
             sb.chars_checked);
    $display("with directed corner cases and random zero runs under varied sender gaps.");
    if (sb.mismatches == 0) begin
      $display("ipv6_canonical_text_formatter_test OK");
    end else begin
      $display("ipv6_canonical_text_formatter_test NOT OK");
    end
    $finish;
  end

endmodule
